// ----- sv/fed_pkg.sv -----
// ----------------------------------------------------------------------------
// fed_pkg
// shared widths, register codes, reset values and the lane control bundle
// of the feedback echo delay unit
// ----------------------------------------------------------------------------
package fed_pkg;

   // store geometry, the depth is a power of two
   localparam int ADDR_W      = 17;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int CHANNELS    = 2;
   localparam int MAX_LANES   = 2;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int DELAY_W  = 17;
   localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
   localparam int RND_W    = PROD_W + 1;
   localparam int ECHO_W   = RND_W - GAIN_W;
   localparam int SUM_W    = ECHO_W + 1;
   localparam int DLY_EXT_W = (ADDR_W > DELAY_W) ? ADDR_W : DELAY_W;

   // configuration port
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_FRAMES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_GAIN    = 1'b1;

   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(48000);
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(6554);

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(8388608);
   localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(32768);

   typedef struct packed {
      logic              accept;
      logic [ADDR_W-1:0] rd_addr;
      logic              live;
      logic              c_load;
      logic              o_load;
      logic [ADDR_W-1:0] wr_addr;
   } fed_ctl_type;

endpackage

// ----- sv/fed_if.sv -----
// ----------------------------------------------------------------------------
// fed_if
// stream channels of the feedback echo delay unit, frames in and frames out
// ----------------------------------------------------------------------------
interface fed_req_if import fed_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] in_left;
   logic signed [SAMPLE_W-1:0] in_right;

   modport source (output valid, output in_left, output in_right, input ready);
   modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface fed_rsp_if import fed_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ----- sv/fed_ram.sv -----
// ----------------------------------------------------------------------------
// fed_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module fed_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/fed_lane.sv -----
// ----------------------------------------------------------------------------
// fed_lane
// one channel: delay store, gain multiply, rounding, sum and saturation
// ----------------------------------------------------------------------------
module fed_lane import fed_pkg::*; (
   input  logic                       clock,
   input  fed_ctl_type                ctl,
   input  logic [GAIN_W-1:0]          gain,
   input  logic signed [SAMPLE_W-1:0] x_in,
   output logic signed [SAMPLE_W-1:0] y_out
);

   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0] delayed;
   logic signed [SAMPLE_W-1:0] x_b_ff;
   logic signed [SAMPLE_W-1:0] x_c_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [RND_W-1:0]    rounded;
   logic signed [ECHO_W-1:0]   echo;
   logic signed [SUM_W-1:0]    total;

   fed_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.o_load),
      .wr_addr (ctl.wr_addr),
      .wr_data (y_out),
      .rd_en   (ctl.accept),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   // never written slots read as zero
   assign delayed = ctl.live ? $signed(rd_data) : '0;
   assign prod_in = PROD_W'(delayed) * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         x_b_ff <= x_in;
      end
      if (ctl.c_load) begin
         prod_ff <= prod_in;
         x_c_ff  <= x_b_ff;
      end
   end

   always_comb begin
      rounded = RND_W'(prod_ff) + ROUND_HALF;
      echo    = rounded[RND_W-1:GAIN_W];
      total   = SUM_W'(x_c_ff) + SUM_W'(echo);
      if (total > SAT_MAX) begin
         y_out = SAT_MAX[SAMPLE_W-1:0];
      end else if (total < SAT_MIN) begin
         y_out = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         y_out = total[SAMPLE_W-1:0];
      end
   end

endmodule

// ----- sv/feedback_echo_delay_unit.sv -----
// ----------------------------------------------------------------------------
// feedback_echo_delay_unit
// stereo feedback comb filter echo with a circular delay store per channel
// ----------------------------------------------------------------------------
// one stereo frame per transaction on req_chan, one result frame per
// transaction on rsp_chan, in order. csr_we writes delay_frames (index 0)
// or echo_gain (index 1); the user must use it only while no frame is in
// flight, the block does not enforce this. each channel runs in its own lane:
// store read, multiply, round, sum and saturate, and the merge stage
// registers both lanes into one result after the read and multiply stages.
// throughput: one frame per cycle while the delay is three frames or more
// and the receiver keeps up; for a delay of one or two frames a new frame
// waits until the frame it echoes has been written back through the store.
// reset clears the write index, the pipeline and the registers to their
// defaults; the store is not swept, slots not yet written since reset read
// as zero, so frames are taken from the first cycle after reset.
// a stalled receiver holds the result; up to two further frames are taken
// into the lanes before req_chan.ready drops.
// ----------------------------------------------------------------------------
module feedback_echo_delay_unit import fed_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fed_req_if.sink               req_chan,
   fed_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   logic [DELAY_W-1:0]   delay_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [ADDR_W-1:0]    wr_idx_ff;
   logic [ADDR_W-1:0]    wr_idx_in;
   logic                 wrapped_ff;
   logic                 wrapped_in;
   logic                 b_v_ff;
   logic                 b_v_in;
   logic                 c_v_ff;
   logic                 c_v_in;
   logic                 o_v_ff;
   logic                 o_v_in;
   logic [ADDR_W-1:0]    b_addr_ff;
   logic [ADDR_W-1:0]    c_addr_ff;
   logic                 b_live_ff;
   logic [DLY_EXT_W-1:0] dly_ext;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 hazard;
   logic                 accept;
   logic                 c_load;
   logic                 o_load;
   fed_ctl_type          ctl;
   logic signed [SAMPLE_W-1:0] lane_x [MAX_LANES];
   logic signed [SAMPLE_W-1:0] lane_y [MAX_LANES];
   logic signed [SAMPLE_W-1:0] out_left_ff;
   logic signed [SAMPLE_W-1:0] out_right_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         gain_ff  <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DELAY_FRAMES: delay_ff <= csr_wdata[DELAY_W-1:0];
            CSR_ECHO_GAIN:    gain_ff  <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign dly_ext = DLY_EXT_W'(delay_ff);
   assign rd_addr = wr_idx_ff - dly_ext[ADDR_W-1:0];

   // pipeline flow
   assign o_load = c_v_ff && (!o_v_ff || rsp_chan.ready);
   assign c_load = b_v_ff && (!c_v_ff || o_load);
   assign hazard = (b_v_ff && (b_addr_ff == rd_addr)) ||
                   (c_v_ff && (c_addr_ff == rd_addr));
   assign req_chan.ready = (!b_v_ff || c_load) && !hazard;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      wr_idx_in  = wr_idx_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         wr_idx_in = wr_idx_ff + 1'b1;
         if (wr_idx_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            wrapped_in = 1'b1;
         end
      end
      b_v_in = accept ? 1'b1 : (c_load ? 1'b0 : b_v_ff);
      c_v_in = c_load ? 1'b1 : (o_load ? 1'b0 : c_v_ff);
      o_v_in = o_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : o_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff  <= '0;
         wrapped_ff <= 1'b0;
         b_v_ff     <= 1'b0;
         c_v_ff     <= 1'b0;
         o_v_ff     <= 1'b0;
      end else begin
         wr_idx_ff  <= wr_idx_in;
         wrapped_ff <= wrapped_in;
         b_v_ff     <= b_v_in;
         c_v_ff     <= c_v_in;
         o_v_ff     <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_addr_ff <= wr_idx_ff;
         b_live_ff <= wrapped_ff || (rd_addr < wr_idx_ff);
      end
      if (c_load) begin
         c_addr_ff <= b_addr_ff;
      end
   end

   assign ctl.accept  = accept;
   assign ctl.rd_addr = rd_addr;
   assign ctl.live    = b_live_ff;
   assign ctl.c_load  = c_load;
   assign ctl.o_load  = o_load;
   assign ctl.wr_addr = c_addr_ff;

   assign lane_x[0] = req_chan.in_left;
   assign lane_x[1] = req_chan.in_right;

   for (genvar c = 0; c < MAX_LANES; c++) begin : g_lane
      if (c < CHANNELS) begin : g_on
         fed_lane u_lane (
            .clock (clock),
            .ctl   (ctl),
            .gain  (gain_ff),
            .x_in  (lane_x[c]),
            .y_out (lane_y[c])
         );
      end else begin : g_off
         assign lane_y[c] = '0;
      end
   end

   // merge stage
   always_ff @(posedge clock) begin
      if (o_load) begin
         out_left_ff  <= lane_y[0];
         out_right_ff <= lane_y[1];
      end
   end

   assign rsp_chan.valid     = o_v_ff;
   assign rsp_chan.out_left  = out_left_ff;
   assign rsp_chan.out_right = out_right_ff;

endmodule
